// ----- rtl/gpsca_pkg.sv -----
// gpsca_pkg: constants shared by the c/a code and carrier replica block
// no dependencies
`timescale 1ns / 1ps

package gpsca_pkg;

  localparam int unsigned PHASE_BITS_DEF = 20;

  localparam int unsigned TAP_W    = 4;
  localparam int unsigned SPMS_W   = 16;
  localparam int unsigned WIN_W    = 20;
  localparam int unsigned STEP_W   = 20;
  localparam int unsigned CHIP_W   = 10;
  localparam int unsigned REM_W    = 17;
  localparam int unsigned LFSR_W   = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [LFSR_W-1:0] LFSR_ONES   = 10'h3FF;
  localparam logic [CHIP_W:0]   CODE_LENGTH = 11'd1023;

  localparam logic [TAP_W-1:0]  TAP_A_RST   = 4'd2;
  localparam logic [TAP_W-1:0]  TAP_B_RST   = 4'd6;
  localparam logic [SPMS_W-1:0] SPMS_RST    = 16'd16368;
  localparam logic [WIN_W-1:0]  WIN_RST     = 20'd16368;
  localparam logic [STEP_W-1:0] STEP_RST    = 20'd4092;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_A  = 3'd0,
    CFG_TAP_B  = 3'd1,
    CFG_SPMS   = 3'd2,
    CFG_WINDOW = 3'd3,
    CFG_STEP   = 3'd4
  } cfg_reg_e;

  // g2 phase-select stage, taps outside 1..10 read zero
  function automatic logic g2_stage(input logic [LFSR_W-1:0] g2, input logic [TAP_W-1:0] tap);
    logic bit_v;
    bit_v = 1'b0;
    case (tap) inside
      [4'd1:4'd10]: bit_v = g2[tap - 4'd1];
      default:      bit_v = 1'b0;
    endcase
    return bit_v;
  endfunction

endpackage

// ----- rtl/gps_ca_code_carrier_replica_top.sv -----
// gps_ca_code_carrier_replica_top: gps l1 c/a code and square-wave carrier replica
// depends on gpsca_pkg
`timescale 1ns / 1ps

// Usage
//   input channel: in_valid_i / in_stall_o carry one sample tick per beat with
//   restart_i; a set restart returns code and carrier to sample zero first.
//   output channel: out_valid_o / out_stall_i carry one replica sample per beat
//   (code chip, chip index, i and q bits, last-of-window flag).
//   config channel: cfg_valid_i / cfg_ready_o write register cfg_index_i with
//   cfg_data_i; ready is always high, a write applies from the next beat and
//   restarts nothing. indexes beyond the register list are ignored.
// Timing
//   an accepted input beat has its result in the output register on the next
//   clock; one beat per cycle sustained while the output is not stalled. the
//   lfsrs, remainder and phase accumulators all update together on each accepted beat.
// Reset and stall
//   reset loads the default registers and puts code and carrier at sample zero.
//   while the output beat is held by out_stall_i, in_stall_o is high; once it
//   is taken a new input beat enters in the same cycle.
module gps_ca_code_carrier_replica_top
  import gpsca_pkg::*;
#(
  parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  code_chip_o,
  output logic [CHIP_W-1:0]     chip_index_o,
  output logic                  in_phase_bit_o,
  output logic                  quadrature_bit_o,
  output logic                  window_last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PW = PHASE_BITS;
  localparam int unsigned SW = ((PW > WIN_W) ? PW : WIN_W) + 1;

  logic [TAP_W-1:0]  tap_a_q, tap_b_q;
  logic [SPMS_W-1:0] spms_q;
  logic [WIN_W-1:0]  win_q;
  logic [STEP_W-1:0] step_q;

  logic [LFSR_W-1:0] g1_q, g1_d, g2_q, g2_d;
  logic [CHIP_W-1:0] chip_q, chip_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [PW-1:0]     ph_i_q, ph_i_d, ph_q_q, ph_q_d;
  logic [WIN_W-1:0]  cnt_q, cnt_d;

  logic              out_valid_q;
  logic              chip_out_q, ibit_out_q, qbit_out_q, last_out_q;
  logic [CHIP_W-1:0] idx_out_q;

  logic              accept;
  logic [PW-1:0]     ph_q_start;
  logic [LFSR_W-1:0] g1_c, g2_c;
  logic [CHIP_W-1:0] chip_c;
  logic [REM_W-1:0]  rem_c, rem_sum;
  logic [PW-1:0]     ph_i_c, ph_q_c;
  logic [WIN_W-1:0]  cnt_c;
  logic              chip_bit, ibit, qbit, last;
  logic [SPMS_W-1:0] divisor;
  logic [CHIP_W:0]   chip_inc;
  logic [SW-1:0]     half_ext, sum_i, sum_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  always_comb begin
    ph_q_start = PW'(SW'(win_q >> 2));

    // restart applies before this sample
    g1_c   = restart_i ? LFSR_ONES : g1_q;
    g2_c   = restart_i ? LFSR_ONES : g2_q;
    chip_c = restart_i ? '0 : chip_q;
    rem_c  = restart_i ? '0 : rem_q;
    ph_i_c = restart_i ? '0 : ph_i_q;
    ph_q_c = restart_i ? ph_q_start : ph_q_q;
    cnt_c  = restart_i ? '0 : cnt_q;

    chip_bit = g1_c[LFSR_W-1] ^ g2_stage(g2_c, tap_a_q) ^ g2_stage(g2_c, tap_b_q);
    half_ext = SW'(win_q >> 1);
    ibit     = SW'(ph_i_c) < half_ext;
    qbit     = SW'(ph_q_c) < half_ext;
    last     = ({1'b0, cnt_c} + (WIN_W + 1)'(1)) >= {1'b0, win_q};

    // code rate accumulator and lfsrs
    divisor  = (spms_q < SPMS_W'(CODE_LENGTH)) ? SPMS_W'(CODE_LENGTH) : spms_q;
    rem_sum  = rem_c + REM_W'(CODE_LENGTH);
    g1_d     = g1_c;
    g2_d     = g2_c;
    chip_d   = chip_c;
    rem_d    = rem_sum;
    chip_inc = {1'b0, chip_c} + (CHIP_W + 1)'(1);
    if (rem_sum >= REM_W'(divisor)) begin
      rem_d  = rem_sum - REM_W'(divisor);
      g1_d   = {g1_c[LFSR_W-2:0], g1_c[9] ^ g1_c[2]};
      g2_d   = {g2_c[LFSR_W-2:0],
                g2_c[9] ^ g2_c[8] ^ g2_c[7] ^ g2_c[5] ^ g2_c[2] ^ g2_c[1]};
      chip_d = chip_inc[CHIP_W-1:0];
      if (chip_inc >= CODE_LENGTH) begin
        chip_d = '0;
        g1_d   = LFSR_ONES;
        g2_d   = LFSR_ONES;
      end
    end

    // carrier phase accumulators, single wrap
    sum_i = SW'(ph_i_c) + SW'(step_q);
    if (sum_i >= SW'(win_q)) sum_i = sum_i - SW'(win_q);
    sum_q = SW'(ph_q_c) + SW'(step_q);
    if (sum_q >= SW'(win_q)) sum_q = sum_q - SW'(win_q);
    ph_i_d = sum_i[PW-1:0];
    ph_q_d = sum_q[PW-1:0];
    cnt_d  = cnt_c + WIN_W'(1);

    if (last) begin
      g1_d   = LFSR_ONES;
      g2_d   = LFSR_ONES;
      chip_d = '0;
      rem_d  = '0;
      ph_i_d = '0;
      ph_q_d = ph_q_start;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_a_q <= TAP_A_RST;
      tap_b_q <= TAP_B_RST;
      spms_q  <= SPMS_RST;
      win_q   <= WIN_RST;
      step_q  <= STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TAP_A:  tap_a_q <= cfg_data_i[TAP_W-1:0];
        CFG_TAP_B:  tap_b_q <= cfg_data_i[TAP_W-1:0];
        CFG_SPMS:   spms_q  <= cfg_data_i[SPMS_W-1:0];
        CFG_WINDOW: win_q   <= cfg_data_i[WIN_W-1:0];
        CFG_STEP:   step_q  <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_q   <= LFSR_ONES;
      g2_q   <= LFSR_ONES;
      chip_q <= '0;
      rem_q  <= '0;
      ph_i_q <= '0;
      ph_q_q <= PW'(SW'(WIN_RST >> 2));
      cnt_q  <= '0;
    end else if (accept) begin
      g1_q   <= g1_d;
      g2_q   <= g2_d;
      chip_q <= chip_d;
      rem_q  <= rem_d;
      ph_i_q <= ph_i_d;
      ph_q_q <= ph_q_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      chip_out_q <= chip_bit;
      idx_out_q  <= chip_c;
      ibit_out_q <= ibit ^ chip_bit;
      qbit_out_q <= qbit ^ chip_bit;
      last_out_q <= last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_chip_o      = chip_out_q;
  assign chip_index_o     = idx_out_q;
  assign in_phase_bit_o   = ibit_out_q;
  assign quadrature_bit_o = qbit_out_q;
  assign window_last_o    = last_out_q;

endmodule
